// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, command and status codes, and the control/status structs
// passed between the queue controller and its datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CMD_W  = 2;
  localparam int TAG_W  = 32;
  localparam int PRIO_W = 32;
  localparam int POS_W  = 6;
  localparam int STS_W  = 2;
  localparam int OCC_W  = 7;
  localparam int WORD_W = TAG_W + PRIO_W;

  localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd3;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY   = 2'd1;
  localparam logic [STS_W-1:0] STS_BAD_POS = 2'd2;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture a transfer, start the first store read
    logic enq_step;  // one insertion step
    logic rem_step;  // one gap closing step
    logic tail;      // tail entry read data is valid
    logic emit;      // load the result register
  } spq_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic start_enq;
    logic start_rem;
    logic start_tail;
    logic enq_more;
    logic rem_more;
  } spq_stat_t;

endpackage
`default_nettype wire

// ===== sv/spq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for queue commands and results.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic                       valid;
  logic                       ready;
  logic [spq_pkg::CMD_W-1:0]  cmd;
  logic [spq_pkg::TAG_W-1:0]  tag_in;
  logic signed [spq_pkg::PRIO_W-1:0] prio_in;
  logic [spq_pkg::POS_W-1:0]  position;

  modport source (output valid, cmd, tag_in, prio_in, position, input ready);
  modport sink   (input valid, cmd, tag_in, prio_in, position, output ready);
endinterface

interface spq_out_if;
  logic                       valid;
  logic                       ready;
  logic [spq_pkg::STS_W-1:0]  status;
  logic [spq_pkg::TAG_W-1:0]  tag_out;
  logic [spq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, status, tag_out, occupancy, input ready);
  modport sink   (input valid, status, tag_out, occupancy, output ready);
endinterface
`default_nettype wire

// ===== sv/spq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = spq_pkg::WORD_W,
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/spq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: takes one transfer, steps the datapath through the
// insertion, gap closing or tail read, if any, then hands the result to the output.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_ctl_t       ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENQ  = 3'd1;
  localparam logic [2:0] S_REM  = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          if (stat.start_enq) begin
            state_nxt = S_ENQ;
          end else if (stat.start_rem) begin
            state_nxt = S_REM;
          end else if (stat.start_tail) begin
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_ENQ: begin
        ctl.enq_step = 1'b1;
        if (!stat.enq_more) begin
          state_nxt = S_DONE;
        end
      end
      S_REM: begin
        ctl.rem_step = 1'b1;
        if (!stat.rem_more) begin
          state_nxt = S_DONE;
        end
      end
      S_TAIL: begin
        ctl.tail  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to free up
        if (!out_valid_r || out_ready) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== sv/spq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_dp
// Queue datapath: entry store, entry count, walking index and the result
// register. Moves one entry per cycle through the store.
// ----------------------------------------------------------------------------
module spq_dp #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [spq_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic [spq_pkg::TAG_W-1:0]          in_tag,
  input  wire logic signed [spq_pkg::PRIO_W-1:0]  in_prio,
  input  wire logic [spq_pkg::POS_W-1:0]          in_position,
  input  wire spq_pkg::spq_ctl_t                  ctl,
  output spq_pkg::spq_stat_t                      stat,
  output logic [spq_pkg::STS_W-1:0]               out_status,
  output logic [spq_pkg::TAG_W-1:0]               out_tag,
  output logic [spq_pkg::OCC_W-1:0]               out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > spq_pkg::POS_W) ? CW : spq_pkg::POS_W;
  localparam int TW = spq_pkg::TAG_W;
  localparam int QW = spq_pkg::PRIO_W;

  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [spq_pkg::CMD_W-1:0]   cmd_r;
  logic [TW-1:0]               tag_r;
  logic [QW-1:0]               prio_r;
  logic [spq_pkg::STS_W-1:0]   res_status_r, res_status_nxt;
  logic [TW-1:0]               res_tag_r, res_tag_nxt;
  logic [spq_pkg::STS_W-1:0]   out_status_r;
  logic [TW-1:0]               out_tag_r;
  logic [spq_pkg::OCC_W-1:0]   out_occ_r;

  logic                        full, empty, pos_bad;
  logic                        we;
  logic [AW-1:0]               raddr;
  logic [spq_pkg::WORD_W-1:0]  wdata, rdata;
  logic [QW-1:0]               key_new, key_old;

  spq_ram #(
    .WIDTH (spq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pos_bad = (PW'(in_position) >= PW'(count_r));

  // sign flip so an unsigned compare orders signed priorities
  assign key_new = prio_r ^ {1'b1, {(QW-1){1'b0}}};
  assign key_old = rdata[QW-1:0] ^ {1'b1, {(QW-1){1'b0}}};

  always_comb begin
    stat            = '0;
    stat.start_enq  = (in_cmd == spq_pkg::CMD_ENQ) && !full;
    stat.start_rem  = (in_cmd == spq_pkg::CMD_REMOVE) && !empty && !pos_bad;
    stat.start_tail = ((in_cmd == spq_pkg::CMD_DEQ) || (in_cmd == spq_pkg::CMD_PEEK))
                      && !empty;
    stat.enq_more   = (idx_r != '0) && (key_new >= key_old);
    stat.rem_more   = ((CW'(idx_r) + CW'(1)) < count_r);
  end

  // read address for the next cycle's step
  always_comb begin
    if (ctl.load) begin
      if (in_cmd == spq_pkg::CMD_REMOVE) begin
        raddr = AW'(in_position) + AW'(1);
      end else begin
        raddr = AW'(count_r - CW'(1));
      end
    end else if (ctl.rem_step) begin
      raddr = idx_r + AW'(2);
    end else begin
      raddr = idx_r - AW'(2);
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    if (ctl.enq_step) begin
      we = 1'b1;
      if (!stat.enq_more) begin
        wdata = {tag_r, prio_r};
      end
    end else if (ctl.rem_step) begin
      we = stat.rem_more;
    end
  end

  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    if (ctl.load) begin
      res_tag_nxt = '0;
      case (in_cmd)
        spq_pkg::CMD_ENQ: begin
          idx_nxt        = AW'(count_r);
          res_status_nxt = full ? spq_pkg::STS_FULL : spq_pkg::STS_OK;
        end
        spq_pkg::CMD_REMOVE: begin
          idx_nxt = AW'(in_position);
          if (empty) begin
            res_status_nxt = spq_pkg::STS_EMPTY;
          end else if (pos_bad) begin
            res_status_nxt = spq_pkg::STS_BAD_POS;
          end else begin
            res_status_nxt = spq_pkg::STS_OK;
          end
        end
        default: begin
          res_status_nxt = empty ? spq_pkg::STS_EMPTY : spq_pkg::STS_OK;
        end
      endcase
    end
    if (ctl.enq_step) begin
      if (stat.enq_more) begin
        idx_nxt = idx_r - AW'(1);
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (ctl.rem_step) begin
      if (stat.rem_more) begin
        idx_nxt = idx_r + AW'(1);
      end else begin
        count_nxt = count_r - CW'(1);
      end
    end
    if (ctl.tail) begin
      res_tag_nxt = rdata[spq_pkg::WORD_W-1:QW];
      if (cmd_r == spq_pkg::CMD_DEQ) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      tag_r  <= in_tag;
      prio_r <= in_prio;
    end
    if (ctl.emit) begin
      out_status_r <= res_status_r;
      out_tag_r    <= res_tag_r;
      out_occ_r    <= spq_pkg::OCC_W'(count_r);
    end
  end

  assign out_status    = out_status_r;
  assign out_tag       = out_tag_r;
  assign out_occupancy = out_occ_r;

endmodule
`default_nettype wire

// ===== sv/sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue held as a priority-sorted list in a single RAM.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result. Entries sit in a RAM
// with one write and one registered read port, largest priority at position
// 0; one entry moves per cycle. An enqueue shifts every stored entry with
// priority less than or equal to the new one up by one position; a remove at
// position p shifts the entries behind it down by one; dequeue and peek read
// the tail entry; a rejected command (empty, full, bad position) goes straight
// to the result. The next command is taken the cycle after the result is
// loaded, while that result may still wait for the sink. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  spq_pkg::spq_ctl_t  ctl;
  spq_pkg::spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_ch.cmd),
    .in_tag        (in_ch.tag_in),
    .in_prio       (in_ch.prio_in),
    .in_position   (in_ch.position),
    .ctl           (ctl),
    .stat          (stat),
    .out_status    (out_ch.status),
    .out_tag       (out_ch.tag_out),
    .out_occupancy (out_ch.occupancy)
  );

endmodule
`default_nettype wire
